// ===== design/sm4_pkg.sv =====
// SM4 shared package: S-box table, round constants and helper functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sm4_pkg;

    localparam int ROUND_COUNT = 32;
    localparam int KEY_ROUND_COUNT = 32;
    localparam int WORD_W = 32;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t w0;
        word_t w1;
        word_t w2;
        word_t w3;
    } block_t;

    localparam logic [1:0] REG_KEY_HIGH     = 2'd0;
    localparam logic [1:0] REG_KEY_LOW      = 2'd1;
    localparam logic [1:0] REG_REVERSE_KEYS = 2'd2;

    localparam word_t FK0 = 32'ha3b1bac6;
    localparam word_t FK1 = 32'h56aa3350;
    localparam word_t FK2 = 32'h677d9197;
    localparam word_t FK3 = 32'hb27022dc;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic word_t sub_word(input word_t v);
        sub_word = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    function automatic word_t rotl(input word_t v, input int n);
        rotl = (v << n) | (v >> (WORD_W - n));
    endfunction

    function automatic word_t round_mix(input word_t v);
        word_t b;
        b = sub_word(v);
        round_mix = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    function automatic word_t key_mix(input word_t v);
        word_t b;
        b = sub_word(v);
        key_mix = b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

    // CK byte j of round i is (4i+j)*7 mod 256
    function automatic word_t ck_word(input logic [4:0] i);
        logic [7:0] base;
        base = {1'b0, i, 2'b00} * 8'd7;
        ck_word = {base, base + 8'd7, base + 8'd14, base + 8'd21};
    endfunction

endpackage
`default_nettype wire

// ===== design/sm4_round_cell.sv =====
// SM4 round cell: one round of the data path, one pipeline register.
// Depends on sm4_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sm4_round_cell
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 valid_in,
    input  sm4_pkg::block_t     blk_in,
    input  sm4_pkg::word_t      rk,
    output logic                valid_out,
    output sm4_pkg::block_t     blk_out
);
    logic            valid_reg;
    sm4_pkg::block_t blk_reg;
    sm4_pkg::block_t blk_next;

    always_comb
    begin
        blk_next.w0 = blk_in.w1;
        blk_next.w1 = blk_in.w2;
        blk_next.w2 = blk_in.w3;
        blk_next.w3 = blk_in.w0 ^ sm4_pkg::round_mix(blk_in.w1 ^ blk_in.w2 ^ blk_in.w3 ^ rk);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

    assign valid_out = valid_reg;
    assign blk_out   = blk_reg;
endmodule
`default_nettype wire

// ===== design/sm4_key_cell.sv =====
// SM4 key expansion cell: derives one round key from the previous four.
// Depends on sm4_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sm4_key_cell
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              go_in,
    input  wire  [4:0]       idx,
    input  sm4_pkg::block_t  k_in,
    output logic             go_out,
    output sm4_pkg::block_t  k_out,
    output sm4_pkg::word_t   rk
);
    logic            go_reg;
    sm4_pkg::block_t k_reg;
    sm4_pkg::block_t k_next;

    always_comb
    begin
        k_next.w0 = k_in.w1;
        k_next.w1 = k_in.w2;
        k_next.w2 = k_in.w3;
        k_next.w3 = k_in.w0 ^ sm4_pkg::key_mix(k_in.w1 ^ k_in.w2 ^ k_in.w3
                                                ^ sm4_pkg::ck_word(idx));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            go_reg <= 1'b0;
        else
            go_reg <= go_in;
    end

    // round key stays held until the next expansion wave passes
    always_ff @(posedge clk)
    begin
        if (go_in)
            k_reg <= k_next;
    end

    assign go_out = go_reg;
    assign k_out  = k_reg;
    assign rk     = k_reg.w3;
endmodule
`default_nettype wire

// ===== design/sm4_block_cipher.sv =====
// SM4 block cipher top level: key expansion chain and round pipeline.
// Depends on sm4_pkg, sm4_round_cell, sm4_key_cell.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   Input: a block transfer happens at a rising edge with start high and
//   busy low. busy is high only while round keys are being expanded:
//   after reset and after each key register write.
//   Output: done pulses for one cycle with result_high/result_low valid.
//   The receiver cannot stall; nothing holds the pipeline.
//   Pipeline: one round cell per stage plus the output register. Throughput:
//   one block per cycle while busy is low, set by the fully unrolled chain
//   of round cells.
//   Key expansion: a chain of ROUND_COUNT key cells; a wave starts at the
//   key register and travels one cell per cycle, each cell latching its
//   round key.
//   Configuration: cfg_we/cfg_index/cfg_data, to be written only while idle; the block does not enforce it.
//   reverse_keys swaps round key order (decryption).
//   Reset: clears keys to zero and runs the expansion of the zero key.
module sm4_block_cipher
#(
    parameter int ROUND_COUNT = sm4_pkg::ROUND_COUNT
)
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          start,
    output logic         busy,
    input  wire  [63:0]  text_high,
    input  wire  [63:0]  text_low,
    output logic         done,
    output logic [63:0]  result_high,
    output logic [63:0]  result_low,
    input  wire          cfg_we,
    input  wire  [1:0]   cfg_index,
    input  wire  [63:0]  cfg_data
);
    localparam int CW = $clog2(ROUND_COUNT + 1);

    logic [63:0]   key_high_reg;
    logic [63:0]   key_low_reg;
    logic          reverse_reg;
    logic          kick_reg;
    logic [CW-1:0] exp_cnt_reg;
    logic [CW-1:0] exp_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            reverse_reg  <= 1'b0;
            kick_reg     <= 1'b1;
        end
        else
        begin
            kick_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    sm4_pkg::REG_KEY_HIGH:
                    begin
                        key_high_reg <= cfg_data;
                        kick_reg     <= 1'b1;
                    end
                    sm4_pkg::REG_KEY_LOW:
                    begin
                        key_low_reg <= cfg_data;
                        kick_reg    <= 1'b1;
                    end
                    sm4_pkg::REG_REVERSE_KEYS: reverse_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // busy counter covers the wave's travel down the key chain
    always_comb
    begin
        if (kick_reg)
            exp_cnt_next = CW'(ROUND_COUNT);
        else if (exp_cnt_reg != '0)
            exp_cnt_next = exp_cnt_reg - 1'b1;
        else
            exp_cnt_next = exp_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            exp_cnt_reg <= CW'(ROUND_COUNT);
        else
            exp_cnt_reg <= exp_cnt_next;
    end

    assign busy = kick_reg || (exp_cnt_reg != '0);

    // key chain
    logic            kgo   [ROUND_COUNT+1];
    sm4_pkg::block_t kblk  [ROUND_COUNT+1];
    sm4_pkg::word_t  rkey  [ROUND_COUNT];

    assign kgo[0]     = kick_reg;
    assign kblk[0].w0 = key_high_reg[63:32] ^ sm4_pkg::FK0;
    assign kblk[0].w1 = key_high_reg[31:0]  ^ sm4_pkg::FK1;
    assign kblk[0].w2 = key_low_reg[63:32]  ^ sm4_pkg::FK2;
    assign kblk[0].w3 = key_low_reg[31:0]   ^ sm4_pkg::FK3;

    // round data chain
    logic            dv   [ROUND_COUNT+1];
    sm4_pkg::block_t dblk [ROUND_COUNT+1];

    assign dv[0]   = start && !busy;
    assign dblk[0] = {text_high, text_low};

    genvar g;
    generate
        for (g = 0; g < ROUND_COUNT; g++)
        begin : g_cells
            sm4_key_cell u_key
            (
                .clk    (clk),
                .rst_n  (rst_n),
                .go_in  (kgo[g]),
                .idx    (5'(g)),
                .k_in   (kblk[g]),
                .go_out (kgo[g+1]),
                .k_out  (kblk[g+1]),
                .rk     (rkey[g])
            );
            sm4_round_cell u_round
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .valid_in  (dv[g]),
                .blk_in    (dblk[g]),
                .rk        (reverse_reg ? rkey[ROUND_COUNT-1-g] : rkey[g]),
                .valid_out (dv[g+1]),
                .blk_out   (dblk[g+1])
            );
        end
    endgenerate

    logic        done_reg;
    logic [63:0] res_hi_reg;
    logic [63:0] res_lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv[ROUND_COUNT];
    end

    // final reversal of word order
    always_ff @(posedge clk)
    begin
        res_hi_reg <= {dblk[ROUND_COUNT].w3, dblk[ROUND_COUNT].w2};
        res_lo_reg <= {dblk[ROUND_COUNT].w1, dblk[ROUND_COUNT].w0};
    end

    assign done        = done_reg;
    assign result_high = res_hi_reg;
    assign result_low  = res_lo_reg;

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        kick_reg |-> busy) else $error("kick without busy");
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(dv[ROUND_COUNT])) else $error("done without stage");
    a_cnt_load: assert property (@(posedge clk) disable iff (!rst_n)
        kick_reg |=> exp_cnt_reg == CW'(ROUND_COUNT)) else $error("count not loaded");
endmodule
`default_nettype wire

// ===== verif/sm4_block_cipher_test.sv =====
// Self-checking testbench for sm4_block_cipher: drives blocks under several keys and
// key orders, predicts each result with an independent SM4 model and compares them.
// Depends on sm4_pkg (register indexes) and the sm4_block_cipher RTL.
`timescale 1ns / 1ps
module sm4_block_cipher_test;
    localparam int ROUNDS = 32;
    localparam int DRAIN_CYCLES = ROUNDS + 8;

    typedef struct packed
    {
        logic [63:0] hi;
        logic [63:0] lo;
    } block_pair_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [63:0] text_high = '0;
    logic [63:0] text_low = '0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = sm4_pkg::REG_KEY_HIGH;
    logic [63:0] cfg_data = '0;
    wire         busy;
    wire         done;
    wire  [63:0] result_high;
    wire  [63:0] result_low;

    sm4_block_cipher dut
    (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .text_high(text_high), .text_low(text_low), .done(done),
        .result_high(result_high), .result_low(result_low),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // S-box table held locally so the predictor stands apart from the design
    logic [7:0] sbox_lut [256];
    initial
    begin
        logic [7:0] t [256];
        t = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
        };
        sbox_lut = t;
    end

    // Predictor state: the key, the key order and the expanded round keys
    logic [63:0] model_key_hi;
    logic [63:0] model_key_lo;
    logic        model_reverse;
    logic [31:0] model_rk [ROUNDS];

    function automatic logic [31:0] tau(input logic [31:0] v);
        return {sbox_lut[v[31:24]], sbox_lut[v[23:16]], sbox_lut[v[15:8]], sbox_lut[v[7:0]]};
    endfunction

    function automatic logic [31:0] rol(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic expand_round_keys();
        logic [31:0] k [4];
        logic [31:0] ck;
        logic [31:0] b;
        logic [31:0] nk;
        k[0] = model_key_hi[63:32] ^ 32'ha3b1bac6;
        k[1] = model_key_hi[31:0]  ^ 32'h56aa3350;
        k[2] = model_key_lo[63:32] ^ 32'h677d9197;
        k[3] = model_key_lo[31:0]  ^ 32'hb27022dc;
        for (int i = 0; i < ROUNDS; i++)
        begin
            for (int j = 0; j < 4; j++)
                ck[31-8*j -: 8] = 8'((4*i + j) * 7);
            b = tau(k[1] ^ k[2] ^ k[3] ^ ck);
            nk = k[0] ^ b ^ rol(b, 13) ^ rol(b, 23);
            model_rk[i] = nk;
            k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = nk;
        end
    endtask

    function automatic block_pair_t sm4_transform(input block_pair_t blk);
        logic [31:0] x [4];
        logic [31:0] rk;
        logic [31:0] b;
        logic [31:0] nx;
        x[0] = blk.hi[63:32]; x[1] = blk.hi[31:0];
        x[2] = blk.lo[63:32]; x[3] = blk.lo[31:0];
        for (int i = 0; i < ROUNDS; i++)
        begin
            rk = model_reverse ? model_rk[ROUNDS-1-i] : model_rk[i];
            b = tau(x[1] ^ x[2] ^ x[3] ^ rk);
            nx = x[0] ^ b ^ rol(b, 2) ^ rol(b, 10) ^ rol(b, 18) ^ rol(b, 24);
            x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nx;
        end
        return '{hi: {x[3], x[2]}, lo: {x[1], x[0]}};
    endfunction

    // Stimulus queue, filled phase by phase; expected results in order
    block_pair_t pending_blocks [$];
    block_pair_t expected_blocks [$];
    int mismatch_count = 0;
    int stray_count = 0;
    int blocks_sent = 0;
    int blocks_seen = 0;
    int phase_count = 0;

    // Driver: one transfer whenever start is high and busy is low at the edge.
    // start stays up across back-to-back transfers; gaps are mostly short.
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_blocks.push_back(sm4_transform('{hi: text_high, lo: text_low}));
                blocks_sent++;
                void'(pending_blocks.pop_front());
            end
            if (start && busy)
                ;   // hold the offered block until the expansion finishes
            else if (gap_left > 0 || pending_blocks.size() <= (start && !busy ? 0 : 0))
            begin
                if (gap_left > 0)
                    gap_left--;
                start <= 1'b0;
            end
            else
            begin
                // pending_blocks[0] is the block to present next
                start <= 1'b1;
                text_high <= pending_blocks[0].hi;
                text_low <= pending_blocks[0].lo;
                if ($urandom_range(0, 99) < 25)
                    gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                          : $urandom_range(1, 3);
            end
        end
    end

    // Monitor: every done pulse is a transfer that must match the oldest expectation
    always @(posedge clk)
    begin
        block_pair_t exp_blk;
        if (rst_n && done)
        begin
            blocks_seen++;
            if (expected_blocks.size() == 0)
            begin
                stray_count++;
                if (mismatch_count + stray_count <= 10)
                    $display("unexpected result %h %h", result_high, result_low);
            end
            else
            begin
                exp_blk = expected_blocks.pop_front();
                if (result_high !== exp_blk.hi || result_low !== exp_blk.lo)
                begin
                    mismatch_count++;
                    if (mismatch_count + stray_count <= 10)
                        $display("mismatch: expected %h %h, got %h %h",
                                 exp_blk.hi, exp_blk.lo, result_high, result_low);
                end
            end
        end
    end

    // Register write at an edge while idle; the predictor follows straight away
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == sm4_pkg::REG_KEY_HIGH)
        begin
            model_key_hi = value;
            expand_round_keys();
        end
        else if (idx == sm4_pkg::REG_KEY_LOW)
        begin
            model_key_lo = value;
            expand_round_keys();
        end
        else if (idx == sm4_pkg::REG_REVERSE_KEYS)
            model_reverse = value[0];
    endtask

    task automatic run_and_drain();
        phase_count++;
        wait (pending_blocks.size() == 0 && !start);
        wait (expected_blocks.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random block: mostly full random, some with sparse or saturated words
    function automatic block_pair_t random_block();
        block_pair_t b;
        b.hi = rand64();
        b.lo = rand64();
        case ($urandom_range(0, 9))
            0: b.hi = '0;
            1: b.lo = '1;
            2: b = '{hi: 64'h1 << $urandom_range(0, 63), lo: 64'h1 << $urandom_range(0, 63)};
            default: ;
        endcase
        return b;
    endfunction

    initial
    begin
        logic [63:0] kh;
        logic [63:0] kl;
        block_pair_t plain [$];
        model_key_hi = '0;
        model_key_lo = '0;
        model_reverse = 1'b0;
        repeat (4) @(posedge clk);
        // S-box table is loaded by now
        expand_round_keys();
        rst_n <= 1'b1;

        // Zero key after reset: edge-case blocks straight into the expansion wait
        pending_blocks.push_back('{hi: '0, lo: '0});
        pending_blocks.push_back('{hi: '1, lo: '1});
        pending_blocks.push_back('{hi: 64'h0123456789abcdef, lo: 64'hfedcba9876543210});
        pending_blocks.push_back('{hi: 64'h8000000000000001, lo: 64'h0000000180000000});
        run_and_drain();

        // Standard test vector key, forward then reverse (decrypts the vector)
        write_reg(sm4_pkg::REG_KEY_HIGH, 64'h0123456789abcdef);
        write_reg(sm4_pkg::REG_KEY_LOW, 64'hfedcba9876543210);
        pending_blocks.push_back('{hi: 64'h0123456789abcdef, lo: 64'hfedcba9876543210});
        pending_blocks.push_back('{hi: '1, lo: '0});
        run_and_drain();
        write_reg(sm4_pkg::REG_REVERSE_KEYS, 64'h1);
        pending_blocks.push_back('{hi: 64'h681edf34d206965e, lo: 64'h86b3e94f536e4246});
        pending_blocks.push_back('{hi: '0, lo: '1});
        run_and_drain();

        // Wide value in the order register: only bit 0 counts
        write_reg(sm4_pkg::REG_REVERSE_KEYS, 64'hfffffffffffffffe);
        pending_blocks.push_back('{hi: 64'h5555aaaa5555aaaa, lo: 64'haaaa5555aaaa5555});
        run_and_drain();

        // All-ones key, both orders
        write_reg(sm4_pkg::REG_KEY_HIGH, '1);
        write_reg(sm4_pkg::REG_KEY_LOW, '1);
        pending_blocks.push_back('{hi: '1, lo: '1});
        pending_blocks.push_back('{hi: '0, lo: '0});
        run_and_drain();
        write_reg(sm4_pkg::REG_REVERSE_KEYS, 64'hffffffffffffffff);
        pending_blocks.push_back('{hi: '1, lo: '1});
        run_and_drain();

        // Random phases: random keys, encrypt a batch, then decrypt the results
        for (int p = 0; p < 6; p++)
        begin
            kh = (p == 0) ? 64'h0 : rand64();
            kl = (p == 5) ? 64'hffffffffffffffff : rand64();
            write_reg(sm4_pkg::REG_KEY_HIGH, kh);
            write_reg(sm4_pkg::REG_KEY_LOW, kl);
            write_reg(sm4_pkg::REG_REVERSE_KEYS, 64'h0);
            plain.delete();
            for (int i = 0; i < 80; i++)
            begin
                plain.push_back(random_block());
                pending_blocks.push_back(plain[i]);
            end
            run_and_drain();
            write_reg(sm4_pkg::REG_REVERSE_KEYS, {$urandom(), $urandom()} | 64'h1);
            foreach (plain[i])
            begin
                model_reverse = 1'b0;
                pending_blocks.push_back(sm4_transform(plain[i]));
            end
            model_reverse = 1'b1;
            run_and_drain();
        end

        // Long random stream, order register random each phase
        for (int p = 0; p < 4; p++)
        begin
            write_reg(sm4_pkg::REG_REVERSE_KEYS, rand64());
            for (int i = 0; i < 80; i++)
                pending_blocks.push_back(random_block());
            run_and_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d blocks sent, %0d results checked over %0d key/order phases",
                 blocks_sent, blocks_seen, phase_count);
        if (mismatch_count == 0 && stray_count == 0 && expected_blocks.size() == 0)
            $display("sm4_block_cipher_test: PASS");
        else
            $display("sm4_block_cipher_test: FAIL");
        $finish;
    end

    // Watchdog well beyond the slowest legal run
    initial
    begin
        #5ms;
        $display("sm4_block_cipher_test: FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
design/sm4_pkg.sv
design/sm4_round_cell.sv
design/sm4_key_cell.sv
design/sm4_block_cipher.sv
verif/sm4_block_cipher_test.sv
